// ----- hdl/mhd_pkg.sv -----
// shared types and constants for the message header deframer
package mhd_pkg;

    localparam logic [7:0]  HDR_LEN = 8'd21;
    localparam logic [15:0] PAD_POS = 16'd20;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_BODY   = 2'd2,
        PH_DROP   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  version;
        logic [31:0] user_id;
        logic [31:0] command;
        logic [15:0] sequence_res;
        logic [7:0]  format_byte;
        logic [7:0]  compress_flag;
        logic [15:0] peer_type;
        logic [15:0] peer_version;
        logic [15:0] body_length;
        logic [7:0]  body_byte;
        logic        last;
    } res_t;

endpackage

// ----- hdl/message_header_deframer_core.sv -----
// top level of the message header deframer: parser front end and result queue
//
//  channel   direction  handshake            payload
//  input     in         push / full          data_byte
//  result    out        empty / pop          kind .. last (12 fields)
//
// one byte is taken per clock while the result queue is not full; the parser
// classifies it in the same cycle and a header, body or error result goes
// straight into the result queue, whose head drives the result ports
// full follows the result queue only: bytes that give no result still wait while
// the queue is full, so a stalled reader stops the stream after QUEUE_DEPTH results
// reset (rst_n low, asynchronous) empties the queue and returns to the header phase
module message_header_deframer_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  version,
    output logic [31:0] user_id,
    output logic [31:0] command,
    output logic [15:0] sequence_res,
    output logic [7:0]  format_byte,
    output logic [7:0]  compress_flag,
    output logic [15:0] peer_type,
    output logic [15:0] peer_version,
    output logic [15:0] body_length,
    output logic [7:0]  body_byte,
    output logic        last
);
    import mhd_pkg::*;

    logic accept;     // input transfer this cycle
    logic res_valid;  // parser produced a result
    res_t res;
    res_t head;       // oldest queued result

    assign accept = push && !full;

    mhd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // results queue up here; the reader pops at its own pace
    mhd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_valid),
        .wr_data (res),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .rd_data (head)
    );

    // result fields straight from the queue head
    assign kind           = head.kind;
    assign version        = head.version;
    assign user_id        = head.user_id;
    assign command        = head.command;
    assign sequence_res   = head.sequence_res;
    assign format_byte    = head.format_byte;
    assign compress_flag  = head.compress_flag;
    assign peer_type      = head.peer_type;
    assign peer_version   = head.peer_version;
    assign body_length    = head.body_length;
    assign body_byte      = head.body_byte;
    assign last           = head.last;

endmodule

// ----- hdl/mhd_front.sv -----
// front end: byte parser, header field capture and result classification
module mhd_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    output logic          res_valid,
    output mhd_pkg::res_t res
);
    import mhd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg;
    logic [7:0]  off_reg;
    logic [7:0]  version_reg;
    logic [31:0] user_id_reg;
    logic [31:0] command_reg;
    logic [15:0] sequence_reg;
    logic [7:0]  format_reg;
    logic [7:0]  compress_reg;
    logic [15:0] peer_type_reg;
    logic [15:0] peer_version_reg;

    logic [16:0] next_pos;
    logic        pad;
    logic        bad_off;
    logic [15:0] blen;
    logic        at_len;
    logic        end_good;
    logic        end_bad;

    assign next_pos = {1'b0, pos_reg} + 17'd1;
    assign pad      = (pos_reg == PAD_POS);
    assign bad_off  = (off_reg < HDR_LEN) || ({8'd0, off_reg} > len_reg);
    assign blen     = len_reg - {8'd0, off_reg};
    assign at_len   = (next_pos >= {1'b0, len_reg});
    assign end_good = (len_reg == {8'd0, HDR_LEN});
    assign end_bad  = (len_reg <= {8'd0, HDR_LEN});

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    pos_next = next_pos[15:0];
                    if (pad)
                    begin
                        if (bad_off)
                        begin
                            if (end_bad)
                            begin
                                pos_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_DROP;
                            end
                        end
                        else if (end_good)
                        begin
                            pos_next = '0;
                        end
                        else if (off_reg == HDR_LEN)
                        begin
                            phase_next = PH_BODY;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (at_len)
                    begin
                        phase_next = PH_HEADER;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = next_pos[15:0];
                    end
                end
                default:
                begin
                    if (at_len)
                    begin
                        phase_next = PH_HEADER;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = next_pos[15:0];
                        if (phase_reg == PH_SKIP && next_pos >= {9'd0, off_reg})
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        res_valid          = 1'b0;
        res.kind           = KIND_HEADER;
        res.version        = version_reg;
        res.user_id        = user_id_reg;
        res.command        = command_reg;
        res.sequence_res   = sequence_reg;
        res.format_byte    = format_reg;
        res.compress_flag  = compress_reg;
        res.peer_type      = peer_type_reg;
        res.peer_version   = peer_version_reg;
        res.body_length    = blen;
        res.body_byte      = 8'd0;
        res.last           = 1'b0;
        case (phase_reg)
            PH_HEADER:
            begin
                res_valid = accept && pad;
                if (bad_off)
                begin
                    res.kind        = KIND_ERROR;
                    res.body_length = 16'd0;
                    res.last        = 1'b1;
                end
                else
                begin
                    res.last = (blen == 16'd0);
                end
            end
            PH_BODY:
            begin
                res_valid     = accept;
                res.kind      = KIND_BODY;
                res.body_byte = data_byte;
                res.last      = at_len;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    // header field capture, little-endian
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            off_reg          <= '0;
            version_reg      <= '0;
            user_id_reg      <= '0;
            command_reg      <= '0;
            sequence_reg     <= '0;
            format_reg       <= '0;
            compress_reg     <= '0;
            peer_type_reg    <= '0;
            peer_version_reg <= '0;
        end
        else if (accept && phase_reg == PH_HEADER)
        begin
            case (pos_reg[4:0])
                5'd0:  len_reg                 <= {8'd0, data_byte};
                5'd1:  len_reg[15:8]           <= data_byte;
                5'd2:  version_reg             <= data_byte;
                5'd3:  user_id_reg[7:0]        <= data_byte;
                5'd4:  user_id_reg[15:8]       <= data_byte;
                5'd5:  user_id_reg[23:16]      <= data_byte;
                5'd6:  user_id_reg[31:24]      <= data_byte;
                5'd7:  command_reg[7:0]        <= data_byte;
                5'd8:  command_reg[15:8]       <= data_byte;
                5'd9:  command_reg[23:16]      <= data_byte;
                5'd10: command_reg[31:24]      <= data_byte;
                5'd11: sequence_reg            <= {8'd0, data_byte};
                5'd12: sequence_reg[15:8]      <= data_byte;
                5'd13: off_reg                 <= data_byte;
                5'd14: format_reg              <= data_byte;
                5'd15: compress_reg            <= data_byte;
                5'd16: peer_type_reg           <= {8'd0, data_byte};
                5'd17: peer_type_reg[15:8]     <= data_byte;
                5'd18: peer_version_reg        <= {8'd0, data_byte};
                5'd19: peer_version_reg[15:8]  <= data_byte;
                default: ;
            endcase
        end
    end

    a_no_result_inside_header: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_HEADER && !pad) |-> !res_valid)
        else $error("result raised before header pad byte");

    a_no_result_when_skipping: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP || phase_reg == PH_DROP) |-> !res_valid)
        else $error("result raised while skipping or discarding");

    a_last_body_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_BODY && res.last)
        |=> (phase_reg == PH_HEADER && pos_reg == 16'd0))
        else $error("frame did not restart after last body byte");

endmodule

// ----- hdl/mhd_queue.sv -----
// back end: result queue that holds finished results until popped
module mhd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mhd_pkg::res_t wr_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output mhd_pkg::res_t rd_data
);
    import mhd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not grow on push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("queue count did not shrink on pop");

endmodule

// ----- tb/tb_message_header_deframer_core.sv -----
// self-checking testbench for the message header deframer core
`timescale 1ns / 1ps

module tb_message_header_deframer_core;

    import mhd_pkg::*;

    // one frame to put on the byte stream; kind, blen and last are typed-in
    // expectations for the header or error result when typed is set
    typedef struct {
        logic [15:0] len;
        logic [7:0]  off;
        int          fill;      // 0 all zero, 1 all ones, 2 random contents
        bit          typed;
        kind_t       kind;
        logic [15:0] blen;
        logic        last;
    } frame_row_t;

    // idle mix per random phase: none, sender only, receiver only, both
    localparam int SEND_IDLE_PCT [4] = '{0, 49, 0, 33};
    localparam int POP_STALL_PCT [4] = '{0, 0, 49, 33};
    localparam int ITEMS_PER_PHASE   = 100;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  kind;
    logic [7:0]  version;
    logic [31:0] user_id;
    logic [31:0] command;
    logic [15:0] sequence_res;
    logic [7:0]  format_byte;
    logic [7:0]  compress_flag;
    logic [15:0] peer_type;
    logic [15:0] peer_version;
    logic [15:0] body_length;
    logic [7:0]  body_byte;
    logic        last;

    // parser state of the local copy of the deframer
    logic [15:0] at_byte;
    logic [15:0] frame_len;
    logic [7:0]  hdr_off;
    logic [7:0]  hdr_version;
    logic [31:0] hdr_user;
    logic [31:0] hdr_command;
    logic [15:0] hdr_sequence;
    logic [7:0]  hdr_format;
    logic [7:0]  hdr_compress;
    logic [15:0] hdr_peer_type;
    logic [15:0] hdr_peer_version;
    phase_t      walk_phase;

    res_t       awaited_records [$];
    frame_row_t directed_frames [14];

    int fail_count;
    int sent_items;         // byte transfers sent
    int send_idle_pct;
    int pop_stall_pct;
    int pop_hold_cycles;    // long receiver hold-off, run down by the receiver

    message_header_deframer_core uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .version        (version),
        .user_id        (user_id),
        .command        (command),
        .sequence_res   (sequence_res),
        .format_byte    (format_byte),
        .compress_flag  (compress_flag),
        .peer_type      (peer_type),
        .peer_version   (peer_version),
        .body_length    (body_length),
        .body_byte      (body_byte),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAIL message_header_deframer_core");
        $finish;
    end

    // one line per mismatch
    task automatic log_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // result record carrying the header fields currently held by the parser
    function automatic res_t stamp_result(input kind_t k, input logic [15:0] blen,
                                          input logic [7:0] bb, input logic lst);
        res_t r;
        r.kind           = k;
        r.version        = hdr_version;
        r.user_id        = hdr_user;
        r.command        = hdr_command;
        r.sequence_res   = hdr_sequence;
        r.format_byte    = hdr_format;
        r.compress_flag  = hdr_compress;
        r.peer_type      = hdr_peer_type;
        r.peer_version   = hdr_peer_version;
        r.body_length    = blen;
        r.body_byte      = bb;
        r.last           = lst;
        return r;
    endfunction

    // advance the local deframer by one byte; returns 1 when a result is due
    function automatic bit parse_byte(input logic [7:0] b, output res_t r);
        int unsigned nxt;
        logic [15:0] blen;
        nxt = int'(at_byte) + 1;
        r   = '0;
        if (walk_phase == PH_HEADER)
        begin
            // little-endian header fields, byte by byte
            case (at_byte)
                16'd0:  frame_len = {8'h00, b};
                16'd1:  frame_len[15:8] = b;
                16'd2:  hdr_version = b;
                16'd3, 16'd4, 16'd5, 16'd6:
                    hdr_user[8 * (at_byte - 16'd3) +: 8] = b;
                16'd7, 16'd8, 16'd9, 16'd10:
                    hdr_command[8 * (at_byte - 16'd7) +: 8] = b;
                16'd11: hdr_sequence = {8'h00, b};
                16'd12: hdr_sequence[15:8] = b;
                16'd13: hdr_off = b;
                16'd14: hdr_format = b;
                16'd15: hdr_compress = b;
                16'd16: hdr_peer_type = {8'h00, b};
                16'd17: hdr_peer_type[15:8] = b;
                16'd18: hdr_peer_version = {8'h00, b};
                16'd19: hdr_peer_version[15:8] = b;
                default: ;
            endcase
            if (at_byte < PAD_POS)
            begin
                at_byte = 16'(nxt);
                return 1'b0;
            end
            // pad byte: header complete, judge the offset
            if (hdr_off < HDR_LEN || 16'(hdr_off) > frame_len)
            begin
                r = stamp_result(KIND_ERROR, 16'd0, 8'd0, 1'b1);
                if (frame_len <= 16'(HDR_LEN))
                begin
                    walk_phase = PH_HEADER;
                    at_byte    = 16'd0;
                end
                else
                begin
                    walk_phase = PH_DROP;
                    at_byte    = 16'(nxt);
                end
                return 1'b1;
            end
            blen = frame_len - 16'(hdr_off);
            r = stamp_result(KIND_HEADER, blen, 8'd0, blen == 16'd0);
            if (frame_len == 16'(HDR_LEN))
            begin
                walk_phase = PH_HEADER;
                at_byte    = 16'd0;
            end
            else
            begin
                walk_phase = (hdr_off == HDR_LEN) ? PH_BODY : PH_SKIP;
                at_byte    = 16'(nxt);
            end
            return 1'b1;
        end
        if (walk_phase == PH_BODY)
        begin
            r = stamp_result(KIND_BODY, frame_len - 16'(hdr_off), b, nxt >= frame_len);
            if (nxt >= frame_len)
            begin
                walk_phase = PH_HEADER;
                at_byte    = 16'd0;
            end
            else
                at_byte = 16'(nxt);
            return 1'b1;
        end
        // option skip or discard of a bad frame: silent
        if (nxt >= frame_len)
        begin
            walk_phase = PH_HEADER;
            at_byte    = 16'd0;
        end
        else
        begin
            if (walk_phase == PH_SKIP && nxt >= hdr_off)
                walk_phase = PH_BODY;
            at_byte = 16'(nxt);
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_byte(input int fill);
        int unsigned roll;
        roll = $urandom_range(99);
        case (fill)
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return (roll < 10) ? 8'h00 : (roll < 20) ? 8'hFF : 8'($urandom());
        endcase
    endfunction

    // mostly well-formed frames with random contents, the rest bad offsets
    // and headers of pure noise
    function automatic frame_row_t random_frame();
        frame_row_t fr;
        int unsigned sel;
        sel      = $urandom_range(99);
        fr.fill  = 2;
        fr.typed = 1'b0;
        fr.kind  = KIND_HEADER;
        fr.blen  = 16'd0;
        fr.last  = 1'b0;
        if (sel < 65)
        begin
            fr.off = ($urandom_range(99) < 60) ? HDR_LEN : 8'(21 + $urandom_range(12));
            if ($urandom_range(99) < 4)
                fr.off = 8'($urandom_range(255, 21));
            fr.len = 16'(int'(fr.off) + (($urandom_range(99) < 90) ? $urandom_range(24)
                                                                   : $urandom_range(120)));
        end
        else if (sel < 75)
        begin
            // offset inside the fixed header
            fr.off = 8'($urandom_range(20));
            fr.len = 16'($urandom_range(60));
        end
        else if (sel < 87)
        begin
            // offset past the end of the frame
            fr.len = 16'($urandom_range(60));
            fr.off = 8'($urandom_range(255, int'(fr.len) + 1));
        end
        else
        begin
            fr.len = 16'($urandom_range(80));
            fr.off = 8'($urandom());
        end
        return fr;
    endfunction

    // offer one byte from a falling edge until a transfer happens at a rising edge
    task automatic send_byte(input logic [7:0] b, input bit apply_typed,
                             input frame_row_t fr);
        res_t rec;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (full);
        if (parse_byte(b, rec))
        begin
            // typed-in fields of the header or error result override the prediction
            if (apply_typed)
            begin
                rec.kind        = fr.kind;
                rec.body_length = fr.blen;
                rec.last        = fr.last;
            end
            awaited_records.push_back(rec);
        end
        sent_items++;
        @(negedge clk);
    endtask

    // whole frame: 21 header bytes, then options and body up to the length
    task automatic send_frame(input frame_row_t fr);
        logic [7:0] hdr [21];
        int         total;
        for (int i = 0; i < 21; i++)
            hdr[i] = pick_byte(fr.fill);
        hdr[0]  = fr.len[7:0];
        hdr[1]  = fr.len[15:8];
        hdr[13] = fr.off;
        total   = (fr.len > 16'(HDR_LEN)) ? int'(fr.len) : 21;
        for (int i = 0; i < total; i++)
            send_byte((i < 21) ? hdr[i] : pick_byte(fr.fill), fr.typed && i == 20, fr);
    endtask

    // sender pause: stream held off until every awaited result has come
    task automatic wait_drained();
        push <= 1'b0;
        do
            @(negedge clk);
        while (awaited_records.size() != 0);
    endtask

    // receiver: pop driven at falling edges, random stalls plus the long hold-off
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pop_hold_cycles > 0)
            begin
                pop_hold_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // result checker: each result transfer against the oldest awaited record
    initial
    begin
        res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (awaited_records.size() == 0)
                    log_mismatch("result transfer with nothing awaited");
                else
                begin
                    want = awaited_records.pop_front();
                    check_field("kind", kind, want.kind);
                    check_field("version", version, want.version);
                    check_field("user_id", user_id, want.user_id);
                    check_field("command", command, want.command);
                    check_field("sequence_res", sequence_res, want.sequence_res);
                    check_field("format_byte", format_byte, want.format_byte);
                    check_field("compress_flag", compress_flag, want.compress_flag);
                    check_field("peer_type", peer_type, want.peer_type);
                    check_field("peer_version", peer_version, want.peer_version);
                    check_field("body_length", body_length, want.body_length);
                    check_field("body_byte", body_byte, want.body_byte);
                    check_field("last", last, want.last);
                end
            end
        end
    end

    // stimulus: directed frames, then random frames over four idle mixes
    initial
    begin
        int         base_items;
        frame_row_t burst;

        push            = 1'b0;
        data_byte       = 8'h00;
        rst_n           = 1'b0;
        fail_count      = 0;
        sent_items      = 0;
        send_idle_pct   = 0;
        pop_stall_pct   = 0;
        pop_hold_cycles = 0;

        // parser state after reset
        at_byte          = 16'd0;
        frame_len        = 16'd0;
        hdr_off          = 8'd0;
        hdr_version      = 8'd0;
        hdr_user         = 32'd0;
        hdr_command      = 32'd0;
        hdr_sequence     = 16'd0;
        hdr_format       = 8'd0;
        hdr_compress     = 8'd0;
        hdr_peer_type    = 16'd0;
        hdr_peer_version = 16'd0;
        walk_phase       = PH_HEADER;

        //                  len       off     fill typed kind         blen     last
        directed_frames = '{
            '{16'd0,     8'd0,   0, 1'b1, KIND_ERROR,  16'd0,  1'b1},  // all-zero header
            '{16'd21,    8'd21,  1, 1'b1, KIND_HEADER, 16'd0,  1'b1},  // bare header, ones
            '{16'd22,    8'd21,  0, 1'b1, KIND_HEADER, 16'd1,  1'b0},  // single zero body byte
            '{16'd22,    8'd22,  2, 1'b1, KIND_HEADER, 16'd0,  1'b1},  // one option, no body
            '{16'd24,    8'd21,  1, 1'b0, KIND_HEADER, 16'd3,  1'b0},
            '{16'd28,    8'd23,  2, 1'b0, KIND_HEADER, 16'd5,  1'b0},  // options then body
            '{16'd25,    8'd25,  2, 1'b1, KIND_HEADER, 16'd0,  1'b1},  // options, empty body
            '{16'd30,    8'd20,  2, 1'b1, KIND_ERROR,  16'd0,  1'b1},  // offset just short
            '{16'd22,    8'd23,  2, 1'b1, KIND_ERROR,  16'd0,  1'b1},  // offset past length
            '{16'd5,     8'd21,  2, 1'b1, KIND_ERROR,  16'd0,  1'b1},  // short frame
            '{16'd21,    8'd255, 1, 1'b1, KIND_ERROR,  16'd0,  1'b1},  // bad, ends at pad
            '{16'd256,   8'd255, 1, 1'b1, KIND_HEADER, 16'd1,  1'b0},  // widest offset
            '{16'd23,    8'd22,  0, 1'b0, KIND_HEADER, 16'd1,  1'b0},
            '{16'd64,    8'd20,  1, 1'b1, KIND_ERROR,  16'd0,  1'b1}   // discard to the length
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_frames[i])
            send_frame(directed_frames[i]);

        for (int mix = 0; mix < 4; mix++)
        begin
            send_idle_pct = SEND_IDLE_PCT[mix];
            pop_stall_pct = POP_STALL_PCT[mix];
            base_items    = sent_items;
            if (mix == 0)
            begin
                // receiver holds off while a long body keeps coming, so the
                // result queue fills and the input stalls on full
                pop_hold_cycles = 300;
                burst           = random_frame();
                burst.len       = 16'd61;
                burst.off       = HDR_LEN;
                send_frame(burst);
                wait_drained();
            end
            while (sent_items - base_items < ITEMS_PER_PHASE)
                send_frame(random_frame());
        end

        // drain, then allow time for any stray result
        wait_drained();
        repeat (8) @(negedge clk);

        if (fail_count == 0)
            $display("PASS message_header_deframer_core");
        else
            $display("FAIL message_header_deframer_core");
        $finish;
    end

endmodule
